@@ design/sfd_pkg.sv @@
// Shared constants and types of the frame deframer.
package sfd_pkg;

  localparam int unsigned PayloadDepth = 64;
  localparam int unsigned IdxW = $clog2(PayloadDepth);
  localparam int unsigned NumBanks = 2;
  localparam int unsigned AddrW = IdxW + 1;
  localparam int unsigned LenW = 6;
  localparam int unsigned LimitW = 7;
  localparam int unsigned CfgIdxW = 2;
  localparam logic [LimitW-1:0] LimitCap =
      LimitW'((PayloadDepth < 64) ? PayloadDepth : 64);

  localparam logic [7:0] SyncValueRst = 8'hAA;
  localparam logic [7:0] FrameTypeRst = 8'h01;
  localparam logic [LimitW-1:0] LengthLimitRst = 7'd60;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSyncValue   = 2'd0,
    CfgFrameType   = 2'd1,
    CfgLengthLimit = 2'd2
  } sfd_cfg_idx_e;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
  } sfd_wr_t;

  typedef struct packed {
    logic            bank;
    logic [LenW-1:0] len;
  } sfd_desc_t;

  typedef struct packed {
    logic active;
    logic bank;
  } sfd_back_status_t;

endpackage

@@ design/sfd_front.sv @@
// Front end: configuration registers, header parser, payload writes and checksum check.
module sfd_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [7:0]                   rx_byte_i,
  input  logic                         cfg_we_i,
  input  logic [sfd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [7:0]                   cfg_wdata_i,
  output sfd_pkg::sfd_wr_t             wr_o,
  output logic                         desc_push_o,
  output sfd_pkg::sfd_desc_t           desc_o
);

  typedef enum logic [5:0] {
    FR_IDLE  = 6'b000001,
    FR_SYNC1 = 6'b000010,
    FR_SYNC2 = 6'b000100,
    FR_TYPE  = 6'b001000,
    FR_DATA  = 6'b010000,
    FR_CHECK = 6'b100000
  } sfd_front_state_e;

  sfd_front_state_e state_q, state_d;
  logic [7:0] sync_value_q, frame_type_q;
  logic [sfd_pkg::LimitW-1:0] length_limit_q;
  logic [sfd_pkg::LenW-1:0] remaining_q, remaining_d;
  logic [sfd_pkg::LenW-1:0] stored_q, stored_d;
  logic [7:0] sum_q, sum_d;
  logic bank_q, bank_d;
  logic [sfd_pkg::LimitW-1:0] eff_limit;
  logic len_ok;

  assign eff_limit = (length_limit_q < sfd_pkg::LimitCap) ? length_limit_q : sfd_pkg::LimitCap;
  assign len_ok = rx_byte_i < {1'b0, eff_limit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_value_q   <= sfd_pkg::SyncValueRst;
      frame_type_q   <= sfd_pkg::FrameTypeRst;
      length_limit_q <= sfd_pkg::LengthLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sfd_pkg::CfgSyncValue:   sync_value_q <= cfg_wdata_i;
        sfd_pkg::CfgFrameType:   frame_type_q <= cfg_wdata_i;
        sfd_pkg::CfgLengthLimit: length_limit_q <= cfg_wdata_i[sfd_pkg::LimitW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    remaining_d = remaining_q;
    stored_d    = stored_q;
    sum_d       = sum_q;
    bank_d      = bank_q;
    wr_o.en     = 1'b0;
    wr_o.addr   = {bank_q, sfd_pkg::IdxW'(stored_q)};
    wr_o.data   = rx_byte_i;
    desc_push_o = 1'b0;
    desc_o.bank = bank_q;
    desc_o.len  = stored_q;
    if (accept_i) begin
      state_d = FR_IDLE;
      unique case (state_q)
        FR_IDLE: begin
          if (rx_byte_i == sync_value_q) begin
            state_d = FR_SYNC1;
            sum_d   = rx_byte_i;
          end
        end
        FR_SYNC1: begin
          if (rx_byte_i == sync_value_q) begin
            state_d = FR_SYNC2;
            sum_d   = sum_q + rx_byte_i;
          end
        end
        FR_SYNC2: begin
          if (rx_byte_i == frame_type_q) begin
            state_d = FR_TYPE;
            sum_d   = sum_q + rx_byte_i;
          end
        end
        FR_TYPE: begin
          if (len_ok) begin
            state_d     = FR_DATA;
            sum_d       = sum_q + rx_byte_i;
            remaining_d = rx_byte_i[sfd_pkg::LenW-1:0];
            stored_d    = '0;
          end
        end
        FR_DATA: begin
          if (remaining_q != '0) begin
            wr_o.en     = ({2'b0, stored_q} < sfd_pkg::PayloadDepth);
            stored_d    = stored_q + 1'b1;
            sum_d       = sum_q + rx_byte_i;
            remaining_d = remaining_q - 1'b1;
            state_d     = (remaining_d == '0) ? FR_CHECK : FR_DATA;
          end
        end
        FR_CHECK: begin
          if (sum_q == rx_byte_i) begin
            desc_push_o = 1'b1;
            bank_d      = ~bank_q;
          end
        end
        default: state_d = FR_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FR_IDLE;
      remaining_q <= '0;
      stored_q    <= '0;
      sum_q       <= '0;
      bank_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      remaining_q <= remaining_d;
      stored_q    <= stored_d;
      sum_q       <= sum_d;
      bank_q      <= bank_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.en |-> (state_q == FR_DATA) && (remaining_q != '0))
    else $error("Payload write outside the data phase.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    desc_push_o |-> (stored_q != '0) && (stored_q < sfd_pkg::LimitCap))
    else $error("Verified frame with an impossible length.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    desc_push_o |=> bank_q != $past(bank_q))
    else $error("Write bank did not swap after a verified frame.");

endmodule

@@ design/sfd_queue.sv @@
// Two-entry queue of verified frame descriptors between the front and back ends.
module sfd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sfd_pkg::sfd_desc_t desc_i,
  input  logic               pop_i,
  output sfd_pkg::sfd_desc_t desc_o,
  output logic               empty_o,
  output logic [1:0]         count_o
);

  sfd_pkg::sfd_desc_t entry_q [sfd_pkg::NumBanks];
  logic wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;

  assign desc_o  = entry_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

  always_comb begin
    count_d = count_q;
    if (push_i && !(pop_i && !empty_o)) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i && !empty_o) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i && !empty_o) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> count_q < 2'd2)
    else $error("Descriptor pushed into a full queue.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'd2)
    else $error("Descriptor count out of range.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd2 || count_q == '0) |-> wr_ptr_q == rd_ptr_q)
    else $error("Queue pointers disagree with the count.");

endmodule

@@ design/sfd_back.sv @@
// Back end: two-bank payload store and replay of verified frames into the output register.
module sfd_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sfd_pkg::sfd_wr_t         wr_i,
  input  sfd_pkg::sfd_desc_t       desc_i,
  input  logic                     desc_empty_i,
  output logic                     desc_pop_o,
  output sfd_pkg::sfd_back_status_t status_o,
  input  logic                     pop_i,
  output logic                     empty_o,
  output logic [7:0]               payload_byte_o,
  output logic                     last_byte_o,
  output logic [sfd_pkg::LenW-1:0] frame_length_o
);

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_READ = 3'b010,
    BK_LOAD = 3'b100
  } sfd_back_state_e;

  sfd_back_state_e state_q, state_d;
  logic [7:0] mem_q [sfd_pkg::NumBanks * sfd_pkg::PayloadDepth];
  logic [7:0] rd_data_q;
  logic rd_en;
  logic bank_q;
  logic [sfd_pkg::LenW-1:0] len_q, idx_q, idx_d;
  logic out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic out_last_q;
  logic [sfd_pkg::LenW-1:0] out_len_q;
  logic out_pop, load, is_last;

  assign out_pop = pop_i && out_valid_q;
  assign is_last = (idx_q == len_q - 1'b1);
  assign load = (state_q == BK_LOAD) && (!out_valid_q || out_pop);
  assign rd_en = (state_q == BK_READ);
  assign desc_pop_o = (state_q == BK_IDLE) && !desc_empty_i;
  assign status_o.active = (state_q != BK_IDLE);
  assign status_o.bank = bank_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[{bank_q, sfd_pkg::IdxW'(idx_q)}];
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      BK_IDLE: begin
        if (desc_pop_o) begin
          state_d = BK_READ;
          idx_d   = '0;
        end
      end
      BK_READ: state_d = BK_LOAD;
      BK_LOAD: begin
        if (load) begin
          state_d = is_last ? BK_IDLE : BK_READ;
          idx_d   = idx_q + 1'b1;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (desc_pop_o) begin
      bank_q <= desc_i.bank;
      len_q  <= desc_i.len;
    end
    if (load) begin
      out_byte_q <= rd_data_q;
      out_last_q <= is_last;
      out_len_q  <= len_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign empty_o        = !out_valid_q;
  assign payload_byte_o = out_byte_q;
  assign last_byte_o    = out_last_q;
  assign frame_length_o = out_len_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop_i) |=> out_valid_q && $stable(out_byte_q) && $stable(out_last_q))
    else $error("Waiting beat changed before it was taken.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.active |-> idx_q < len_q)
    else $error("Replay index ran past the frame length.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && is_last) |=> state_q == BK_IDLE)
    else $error("Replay did not finish after the last beat.");

endmodule

@@ design/sync_frame_deframer_sum8.sv @@
// Top level of the sync/type/length frame deframer with an 8-bit sum checksum.
// The parser takes one received byte per cycle while full is low; full only rises while two
// verified frames still hold both payload banks. After the checksum beat of a good frame its
// descriptor is queued, and every payload beat passes through the registered read of the
// payload store followed by the load of the output register.
// Reset clears all control state at once; the store is left as it is and needs no clearing.
module sync_frame_deframer_sum8 (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [7:0]                  rx_byte_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [7:0]                  payload_byte_o,
  output logic                        last_byte_o,
  output logic [5:0]                  frame_length_o,
  input  logic                        cfg_we_i,
  input  logic [sfd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]                  cfg_wdata_i
);

  sfd_pkg::sfd_wr_t wr;
  sfd_pkg::sfd_desc_t desc_in, desc_out;
  sfd_pkg::sfd_back_status_t back_status;
  logic desc_push, desc_pop, desc_empty;
  logic [1:0] desc_count, banks_busy;
  logic accept;

  assign banks_busy = desc_count + 2'(back_status.active);
  assign full = (banks_busy == 2'd2);
  assign accept = push && !full;

  sfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .wr_o        (wr),
    .desc_push_o (desc_push),
    .desc_o      (desc_in)
  );

  sfd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (desc_push),
    .desc_i  (desc_in),
    .pop_i   (desc_pop),
    .desc_o  (desc_out),
    .empty_o (desc_empty),
    .count_o (desc_count)
  );

  sfd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .wr_i           (wr),
    .desc_i         (desc_out),
    .desc_empty_i   (desc_empty),
    .desc_pop_o     (desc_pop),
    .status_o       (back_status),
    .pop_i          (pop),
    .empty_o        (empty),
    .payload_byte_o (payload_byte_o),
    .last_byte_o    (last_byte_o),
    .frame_length_o (frame_length_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    banks_busy <= 2'd2)
    else $error("More payload banks in use than exist.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr.en && back_status.active) |-> wr.addr[sfd_pkg::AddrW-1] != back_status.bank)
    else $error("Payload written into the bank under replay.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (desc_count != '0 && !back_status.active) |=> back_status.active)
    else $error("Waiting frame was not picked up by the back end.");

endmodule

@@ dv/tb_sync_frame_deframer_sum8.sv @@
// Self-checking testbench for the frame deframer: random frames and config phases, scoreboard.
module tb_sync_frame_deframer_sum8;

  localparam logic [sfd_pkg::CfgIdxW-1:0] CfgIdxSpare = 2'd3;
  localparam int unsigned SettleCycles = 12;

  typedef enum logic [2:0] {
    PhIdle, PhSync1, PhSync2, PhType, PhData, PhCheck
  } rx_phase_e;

  typedef enum logic [1:0] {
    StepByte, StepCfg, StepDrain
  } step_kind_e;

  typedef struct packed {
    step_kind_e                  kind;
    logic [sfd_pkg::CfgIdxW-1:0] idx;
    logic [7:0]                  value;
  } rx_step_t;

  typedef struct packed {
    logic [7:0]               payload;
    logic                     last;
    logic [sfd_pkg::LenW-1:0] length;
  } payload_beat_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          push = 1'b0;
  logic                          full;
  logic [7:0]                    rx_byte_i = 8'h00;
  logic                          empty;
  logic                          pop = 1'b0;
  logic [7:0]                    payload_byte_o;
  logic                          last_byte_o;
  logic [5:0]                    frame_length_o;
  logic                          cfg_we_i = 1'b0;
  logic [sfd_pkg::CfgIdxW-1:0]   cfg_idx_i = sfd_pkg::CfgSyncValue;
  logic [7:0]                    cfg_wdata_i = 8'h00;

  rx_step_t                      rx_pending[$];
  payload_beat_t                 payload_due[$];
  int unsigned                   fail_count = 0;
  int unsigned                   queued_bytes = 0;

  logic                          in_beat = 1'b0;
  logic                          out_beat = 1'b0;
  int unsigned                   rx_gap = 0;
  int unsigned                   rx_burst = 0;
  int unsigned                   pop_gap = 0;
  int unsigned                   pop_burst = 0;
  int unsigned                   quiet_cycles = 0;

  logic [7:0]                    tx_sync = sfd_pkg::SyncValueRst;
  logic [7:0]                    tx_type = sfd_pkg::FrameTypeRst;
  logic [sfd_pkg::LimitW-1:0]    tx_limit = sfd_pkg::LengthLimitRst;

  logic [7:0]                    exp_sync = sfd_pkg::SyncValueRst;
  logic [7:0]                    exp_type = sfd_pkg::FrameTypeRst;
  logic [sfd_pkg::LimitW-1:0]    exp_limit = sfd_pkg::LengthLimitRst;
  rx_phase_e                     exp_phase = PhIdle;
  logic [sfd_pkg::LenW-1:0]      exp_remaining = '0;
  logic [sfd_pkg::LenW-1:0]      exp_stored = '0;
  logic [7:0]                    exp_sum = '0;
  logic [7:0]                    exp_store [sfd_pkg::PayloadDepth];

  sync_frame_deframer_sum8 uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .rx_byte_i      (rx_byte_i),
    .empty          (empty),
    .pop            (pop),
    .payload_byte_o (payload_byte_o),
    .last_byte_o    (last_byte_o),
    .frame_length_o (frame_length_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  task automatic draw_gap(inout int unsigned burst, output int unsigned gap);
    int unsigned r;
    if (burst > 0) begin
      burst = burst - 1;
      gap = 0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        burst = $urandom_range(10, 40);
        gap = 0;
      end else if (r < 45) begin
        gap = 0;
      end else if (r < 90) begin
        gap = $urandom_range(1, 3);
      end else begin
        gap = $urandom_range(8, 40);
      end
    end
  endtask

  function automatic void parse_rx_byte(logic [7:0] b);
    logic [sfd_pkg::LimitW-1:0] lim;
    payload_beat_t              beat;
    lim = (exp_limit < sfd_pkg::LimitCap) ? exp_limit : sfd_pkg::LimitCap;
    if (exp_phase == PhIdle && b == exp_sync) begin
      exp_phase = PhSync1;
      exp_sum = b;
    end else if (exp_phase == PhSync1 && b == exp_sync) begin
      exp_phase = PhSync2;
      exp_sum = exp_sum + b;
    end else if (exp_phase == PhSync2 && b == exp_type) begin
      exp_phase = PhType;
      exp_sum = exp_sum + b;
    end else if (exp_phase == PhType && {1'b0, b} < {2'b00, lim}) begin
      exp_phase = PhData;
      exp_sum = exp_sum + b;
      exp_remaining = b[sfd_pkg::LenW-1:0];
      exp_stored = '0;
    end else if (exp_phase == PhData && exp_remaining != 0) begin
      exp_store[exp_stored] = b;
      exp_stored = exp_stored + 1'b1;
      exp_sum = exp_sum + b;
      exp_remaining = exp_remaining - 1'b1;
      if (exp_remaining == 0) exp_phase = PhCheck;
    end else if (exp_phase == PhCheck) begin
      exp_phase = PhIdle;
      if (exp_sum == b) begin
        for (int k = 0; k < int'(exp_stored); k++) begin
          beat.payload = exp_store[k];
          beat.last = (k + 1 == int'(exp_stored));
          beat.length = exp_stored;
          payload_due.push_back(beat);
        end
      end
    end else begin
      exp_phase = PhIdle;
    end
  endfunction

  always @(posedge clk_i) begin
    in_beat <= push && !full;
    out_beat <= pop && !empty;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (payload_due.size() == 0) begin
          $error("result beat with no payload byte expected");
          fail_count++;
        end else begin
          if (payload_byte_o !== payload_due[0].payload) begin
            $error("payload_byte: expected %0h, got %0h", payload_due[0].payload,
                   payload_byte_o);
            fail_count++;
          end
          if (last_byte_o !== payload_due[0].last) begin
            $error("last_byte: expected %0h, got %0h", payload_due[0].last, last_byte_o);
            fail_count++;
          end
          if (frame_length_o !== payload_due[0].length) begin
            $error("frame_length: expected %0d, got %0d", payload_due[0].length,
                   frame_length_o);
            fail_count++;
          end
          void'(payload_due.pop_front());
        end
      end
      if (push && !full) parse_rx_byte(rx_byte_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sfd_pkg::CfgSyncValue:   exp_sync = cfg_wdata_i;
          sfd_pkg::CfgFrameType:   exp_type = cfg_wdata_i;
          sfd_pkg::CfgLengthLimit: exp_limit = cfg_wdata_i[sfd_pkg::LimitW-1:0];
          default: ;
        endcase
      end
    end
  end

  always @(negedge clk_i) begin : drive_rx
    logic                        push_n;
    logic [7:0]                  byte_n;
    logic                        we_n;
    logic [sfd_pkg::CfgIdxW-1:0] idx_n;
    logic [7:0]                  wdata_n;
    push_n = push;
    byte_n = rx_byte_i;
    we_n = 1'b0;
    idx_n = cfg_idx_i;
    wdata_n = cfg_wdata_i;
    if (rst_ni) begin
      if (push && in_beat) push_n = 1'b0;
      if (!push_n) begin
        if (rx_gap > 0) begin
          rx_gap--;
        end else if (rx_pending.size() > 0) begin
          case (rx_pending[0].kind)
            StepByte: begin
              push_n = 1'b1;
              byte_n = rx_pending[0].value;
              void'(rx_pending.pop_front());
              draw_gap(rx_burst, rx_gap);
            end
            StepCfg: begin
              we_n = 1'b1;
              idx_n = rx_pending[0].idx;
              wdata_n = rx_pending[0].value;
              void'(rx_pending.pop_front());
            end
            default: begin
              if (payload_due.size() == 0) quiet_cycles++;
              else quiet_cycles = 0;
              if (quiet_cycles >= SettleCycles) begin
                quiet_cycles = 0;
                void'(rx_pending.pop_front());
              end
            end
          endcase
        end
      end
    end
    push <= push_n;
    rx_byte_i <= byte_n;
    cfg_we_i <= we_n;
    cfg_idx_i <= idx_n;
    cfg_wdata_i <= wdata_n;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_beat) draw_gap(pop_burst, pop_gap);
      if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic add_byte(input logic [7:0] b);
    rx_step_t s;
    s.kind = StepByte;
    s.idx = sfd_pkg::CfgSyncValue;
    s.value = b;
    rx_pending.push_back(s);
    queued_bytes++;
  endtask

  task automatic add_cfg(input logic [sfd_pkg::CfgIdxW-1:0] idx, input logic [7:0] value);
    rx_step_t s;
    s.kind = StepCfg;
    s.idx = idx;
    s.value = value;
    rx_pending.push_back(s);
  endtask

  task automatic add_drain();
    rx_step_t s;
    s.kind = StepDrain;
    s.idx = sfd_pkg::CfgSyncValue;
    s.value = 8'h00;
    rx_pending.push_back(s);
  endtask

  task automatic set_config(input logic [7:0] sync_v, input logic [7:0] type_v,
                            input logic [7:0] limit_v);
    add_drain();
    add_cfg(sfd_pkg::CfgSyncValue, sync_v);
    add_cfg(sfd_pkg::CfgFrameType, type_v);
    add_cfg(sfd_pkg::CfgLengthLimit, limit_v);
    tx_sync = sync_v;
    tx_type = type_v;
    tx_limit = limit_v[sfd_pkg::LimitW-1:0];
  endtask

  task automatic add_frame(input int unsigned len, input bit bad_sum, input int corrupt_at);
    logic [7:0] sum;
    logic [7:0] b;
    sum = 8'h00;
    for (int i = 0; i < int'(len) + 5; i++) begin
      if (i < 2) b = tx_sync;
      else if (i == 2) b = tx_type;
      else if (i == 3) b = 8'(len);
      else if (i < int'(len) + 4) b = 8'($urandom);
      else b = bad_sum ? sum + 8'($urandom_range(1, 255)) : sum;
      sum = sum + b;
      if (i == corrupt_at) b = 8'($urandom);
      add_byte(b);
    end
  endtask

  task automatic random_traffic(input int unsigned budget);
    int unsigned start;
    int unsigned lim;
    int unsigned len;
    int unsigned r;
    start = queued_bytes;
    lim = (tx_limit < sfd_pkg::LimitCap) ? tx_limit : sfd_pkg::LimitCap;
    while (queued_bytes - start < budget) begin
      if (lim == 0) len = $urandom_range(0, 8);
      else if ($urandom_range(0, 7) == 0) len = $urandom_range(0, lim - 1);
      else len = $urandom_range(0, (lim - 1 < 8) ? lim - 1 : 8);
      r = $urandom_range(0, 99);
      if (r < 65) begin
        add_frame(len, 1'b0, -1);
      end else if (r < 75) begin
        add_frame(len, 1'b1, -1);
      end else if (r < 88) begin
        add_frame(len, 1'b0, $urandom_range(0, len + 4));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          add_byte(($urandom_range(0, 3) == 0) ? tx_sync : 8'($urandom));
        end
      end
      if ($urandom_range(0, 19) == 0) add_drain();
    end
  endtask

  initial begin
    add_frame(1, 1'b0, -1);
    add_byte(8'hAA); add_byte(8'hAA); add_byte(8'h01); add_byte(8'h00); add_byte(8'hAA);
    add_byte(8'hAA); add_byte(8'h01); add_byte(8'h01);
    add_frame(2, 1'b1, -1);
    add_byte(8'hAA); add_byte(8'hAA); add_byte(8'h01); add_byte(8'h3C);
    add_drain();
    add_cfg(CfgIdxSpare, 8'($urandom));
    random_traffic(12);
    set_config(8'h00, 8'h00, 8'h01);
    random_traffic(4);
    set_config(8'h55, 8'h80, 8'hFF);
    add_frame(63, 1'b0, -1);
    add_frame(3, 1'b0, -1);
    set_config(8'($urandom), 8'($urandom), 8'h00);
    random_traffic(4);
    set_config(8'($urandom), 8'($urandom), 8'($urandom_range(2, 63)));
    random_traffic(6);
    set_config(sfd_pkg::SyncValueRst, sfd_pkg::FrameTypeRst, 8'(sfd_pkg::LengthLimitRst));
    random_traffic(6);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (rx_pending.size() != 0 || push || payload_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (payload_due.size() != 0) begin
      $error("%0d expected payload bytes never arrived", payload_due.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
